// ===== rtl/core/integer_to_ascii_radix_defines.svh =====
// assertion macros used by rtl/core/itoa_back.sv
`ifndef INTEGER_TO_ASCII_RADIX_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ITOA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ITOA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/itoa_pkg.sv =====
package itoa_pkg;

  localparam int unsigned MAG_W            = 64;
  localparam int unsigned RADIX_W          = 6;
  localparam int unsigned CAP_W            = 7;
  localparam int unsigned CHAR_W           = 8;
  localparam int unsigned MAX_CAPACITY_DEF = 64;
  localparam int unsigned QUEUE_DEPTH      = 2;
  localparam int unsigned DIV_STEPS        = 8;
  localparam int unsigned DIV_CYCLES       = MAG_W / DIV_STEPS;
  localparam int unsigned DIV_CNT_W        = $clog2(DIV_CYCLES);

  localparam logic [RADIX_W-1:0] RADIX_MIN  = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX  = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] DIGIT_TEN  = RADIX_W'(10);

  localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;

  typedef enum logic [1:0] {
    CMD_NO_CAP,
    CMD_EMPTY,
    CMD_CONVERT
  } cmd_kind_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CHECK,
    BK_DIV,
    BK_EMIT,
    BK_LOAD,
    BK_TERM
  } back_state_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [MAG_W-1:0]   mag;
    logic               negative;
    logic [RADIX_W-1:0] radix;
    logic               upper;
    logic [CAP_W-1:0]   room;
  } cmd_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] base;
    if (d < DIGIT_TEN) begin
      return CHAR_ZERO + CHAR_W'(d);
    end
    base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
    return base + CHAR_W'(d - DIGIT_TEN);
  endfunction

endpackage

// ===== rtl/core/itoa_ram.sv =====
module itoa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/itoa_front.sv =====
module itoa_front #(
  parameter int unsigned MAX_CAPACITY = itoa_pkg::MAX_CAPACITY_DEF
) (
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [itoa_pkg::MAG_W-1:0]   number_i,
  input  logic [itoa_pkg::RADIX_W-1:0]        radix_i,
  input  logic                                upper_case_i,
  input  logic [itoa_pkg::CAP_W-1:0]          capacity_i,
  output logic                                cmd_valid_o,
  input  logic                                cmd_stall_i,
  output itoa_pkg::cmd_t                      cmd_o
);
  import itoa_pkg::*;

  logic [CAP_W-1:0] cap_sat;
  logic             negative;

  assign cap_sat  = (capacity_i > CAP_W'(MAX_CAPACITY)) ? CAP_W'(MAX_CAPACITY) : capacity_i;
  assign negative = number_i[MAG_W-1];

  always_comb begin
    cmd_o.mag      = negative ? (MAG_W'(0) - $unsigned(number_i)) : $unsigned(number_i);
    cmd_o.negative = negative;
    cmd_o.radix    = radix_i;
    cmd_o.upper    = upper_case_i;
    cmd_o.room     = cap_sat - CAP_W'(1);
    if (cap_sat == '0) begin
      cmd_o.kind = CMD_NO_CAP;
    end else if (radix_i < RADIX_MIN || radix_i > RADIX_MAX) begin
      cmd_o.kind = CMD_EMPTY;
    end else begin
      cmd_o.kind = CMD_CONVERT;
    end
  end

  assign cmd_valid_o = in_valid_i;
  assign in_stall_o  = cmd_stall_i;

endmodule

// ===== rtl/core/itoa_queue.sv =====
module itoa_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  itoa_pkg::cmd_t in_cmd_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output itoa_pkg::cmd_t out_cmd_o
);
  import itoa_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign in_stall_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_cmd_o   = entry_q[rd_ptr_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= in_cmd_i;
    end
  end

endmodule

// ===== rtl/core/itoa_back.sv =====
`include "integer_to_ascii_radix_defines.svh"

module itoa_back #(
  parameter int unsigned MAX_CAPACITY = itoa_pkg::MAX_CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_stall_o,
  input  itoa_pkg::cmd_t                cmd_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [itoa_pkg::CHAR_W-1:0]   character_o,
  output logic                          written_o,
  output logic                          final_item_o,
  output logic [itoa_pkg::CAP_W-1:0]    length_o
);
  import itoa_pkg::*;

  localparam int unsigned AW = $clog2(MAX_CAPACITY);

  back_state_e        state_q, state_d;
  logic [MAG_W-1:0]   mag_q, mag_d;
  logic [RADIX_W-1:0] rem_q, rem_d;
  logic [RADIX_W-1:0] radix_q, radix_d;
  logic               upper_q, upper_d;
  logic               neg_q, neg_d;
  logic               wr_q, wr_d;
  logic [AW-1:0]      room_q, room_d;
  logic [AW-1:0]      count_q, count_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [DIV_CNT_W-1:0] cyc_q, cyc_d;

  logic               out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]  char_q, char_d;
  logic               written_q, written_d;
  logic               fin_q, fin_d;
  logic [CAP_W-1:0]   len_q, len_d;

  logic               out_free;
  logic               ram_we;
  logic [CHAR_W-1:0]  ram_wdata;
  logic [CHAR_W-1:0]  ram_rdata;
  logic [AW-1:0]      ram_raddr;

  logic [MAG_W-1:0]   step_mag;
  logic [RADIX_W-1:0] step_rem;

  // DIV_STEPS restoring steps of mag / radix per cycle, quotient shifted in at the bottom
  always_comb begin
    logic [RADIX_W:0]     t;
    logic [RADIX_W-1:0]   r;
    logic [DIV_STEPS-1:0] qb;
    r  = rem_q;
    qb = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {r, mag_q[MAG_W-1-i]};
      if (t >= {1'b0, radix_q}) begin
        r = RADIX_W'(t - {1'b0, radix_q});
        qb[DIV_STEPS-1-i] = 1'b1;
      end else begin
        r = t[RADIX_W-1:0];
      end
    end
    step_rem = r;
    step_mag = {mag_q[MAG_W-DIV_STEPS-1:0], qb};
  end

  assign out_free    = !out_valid_q || !out_stall_i;
  assign cmd_stall_o = (state_q != BK_IDLE);
  assign ram_raddr   = idx_q - AW'(1);

  always_comb begin
    state_d   = state_q;
    mag_d     = mag_q;
    rem_d     = rem_q;
    radix_d   = radix_q;
    upper_d   = upper_q;
    neg_d     = neg_q;
    wr_d      = wr_q;
    room_d    = room_q;
    count_d   = count_q;
    idx_d     = idx_q;
    cyc_d     = cyc_q;
    char_d    = char_q;
    written_d = written_q;
    fin_d     = fin_q;
    len_d     = len_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we    = 1'b0;
    ram_wdata = CHAR_ZERO;

    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          mag_d   = cmd_i.mag;
          radix_d = cmd_i.radix;
          upper_d = cmd_i.upper;
          neg_d   = cmd_i.negative;
          room_d  = AW'(cmd_i.room);
          wr_d    = (cmd_i.kind != CMD_NO_CAP);
          count_d = '0;
          state_d = (cmd_i.kind == CMD_CONVERT) ? BK_CHECK : BK_TERM;
        end
      end
      BK_CHECK: begin
        if (count_q == room_q) begin
          idx_d   = count_q;
          state_d = BK_EMIT;
        end else if (mag_q != '0) begin
          rem_d   = '0;
          cyc_d   = '0;
          state_d = BK_DIV;
        end else if (count_q == '0) begin
          // zero value
          ram_we    = 1'b1;
          ram_wdata = CHAR_ZERO;
          count_d   = count_q + AW'(1);
          idx_d     = count_q + AW'(1);
          state_d   = BK_EMIT;
        end else if (neg_q) begin
          ram_we    = 1'b1;
          ram_wdata = CHAR_MINUS;
          count_d   = count_q + AW'(1);
          idx_d     = count_q + AW'(1);
          state_d   = BK_EMIT;
        end else begin
          idx_d   = count_q;
          state_d = BK_EMIT;
        end
      end
      BK_DIV: begin
        mag_d = step_mag;
        rem_d = step_rem;
        cyc_d = cyc_q + DIV_CNT_W'(1);
        if (cyc_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          ram_we    = 1'b1;
          ram_wdata = digit_char(step_rem, upper_q);
          count_d   = count_q + AW'(1);
          cyc_d     = '0;
          state_d   = BK_CHECK;
        end
      end
      BK_EMIT: begin
        state_d = (idx_q == '0) ? BK_TERM : BK_LOAD;
      end
      BK_LOAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = ram_rdata;
          written_d   = 1'b1;
          fin_d       = 1'b0;
          len_d       = '0;
          idx_d       = idx_q - AW'(1);
          state_d     = BK_EMIT;
        end
      end
      BK_TERM: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = CHAR_NUL;
          written_d   = wr_q;
          fin_d       = 1'b1;
          len_d       = CAP_W'(count_q);
          state_d     = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      cyc_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
      fin_q       <= 1'b0;
      len_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      cyc_q       <= cyc_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      fin_q       <= fin_d;
      len_q       <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q     <= mag_d;
    radix_q   <= radix_d;
    upper_q   <= upper_d;
    neg_q     <= neg_d;
    wr_q      <= wr_d;
    room_q    <= room_d;
    char_q    <= char_d;
    written_q <= written_d;
  end

  itoa_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_CAPACITY)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign character_o  = char_q;
  assign written_o    = written_q;
  assign final_item_o = fin_q;
  assign length_o     = len_q;

  `ITOA_ASSERT_IMP(a_len_only_final, out_valid_q && !fin_q, len_q == '0, "length on a non-final beat")
  `ITOA_ASSERT_IMP(a_count_in_room, state_q != BK_IDLE, count_q <= room_q, "digit count past room")
  `ITOA_ASSERT_IMP(a_rem_below_radix, state_q == BK_DIV, rem_q < radix_q, "remainder not below radix")
  `ITOA_ASSERT_IMP(a_cyc_idle, state_q != BK_DIV, cyc_q == '0, "divide counter left running")
  `ITOA_ASSERT_NXT(a_term_done, (state_q == BK_TERM) && out_free, state_q == BK_IDLE, "terminator not closing run")

endmodule

// ===== rtl/core/integer_to_ascii_radix.sv =====
// Converts a signed 64-bit number to ASCII text in base 2 to 36, one character per output beat,
// most significant first, then a zero terminator beat with final_item set and length holding
// the character count. capacity is the buffer size including the terminator (clamped to
// MAX_CAPACITY); only the least significant capacity-1 characters are kept and a minus sign
// only if it still fits. Invalid radix gives just the terminator; capacity zero gives one
// terminator beat with written low. Input items enter a two-entry command queue, so up to two
// items are taken while one is converting. Each kept digit takes a check state plus a pass through
// the shared divider, which retires 8 quotient bits a cycle. Each character then leaves through
// the registered read of the digit RAM in the emit and load states, and each item also passes
// through pop, the last check (sign or zero digit), the last read and the terminator.
module integer_to_ascii_radix #(
  parameter int unsigned MAX_CAPACITY = itoa_pkg::MAX_CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [itoa_pkg::MAG_W-1:0] number_i,
  input  logic [itoa_pkg::RADIX_W-1:0]      radix_i,
  input  logic                              upper_case_i,
  input  logic [itoa_pkg::CAP_W-1:0]        capacity_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [itoa_pkg::CHAR_W-1:0]       character_o,
  output logic                              written_o,
  output logic                              final_item_o,
  output logic [itoa_pkg::CAP_W-1:0]        length_o
);
  import itoa_pkg::*;

  logic cmd_valid, cmd_stall;
  cmd_t cmd;
  logic q_valid, q_stall;
  cmd_t q_cmd;

  itoa_front #(
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .number_i     (number_i),
    .radix_i      (radix_i),
    .upper_case_i (upper_case_i),
    .capacity_i   (capacity_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_stall_i  (cmd_stall),
    .cmd_o        (cmd)
  );

  itoa_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_valid),
    .in_stall_o  (cmd_stall),
    .in_cmd_i    (cmd),
    .out_valid_o (q_valid),
    .out_stall_i (q_stall),
    .out_cmd_o   (q_cmd)
  );

  itoa_back #(
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_stall_o  (q_stall),
    .cmd_i        (q_cmd),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .character_o  (character_o),
    .written_o    (written_o),
    .final_item_o (final_item_o),
    .length_o     (length_o)
  );

endmodule
